@@ rtl/core/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the json string unescaper: the status codes and
// the descriptor that travels from the classifier to the byte sequencer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // code point width, enough for U+10FFFF
  localparam int CP_W = 21;

  // end-of-string status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOQUOTE = 3'd1;
  localparam logic [2:0] ST_UNCLOSE = 3'd2;
  localparam logic [2:0] ST_ESCEND  = 3'd3;
  localparam logic [2:0] ST_BADHEX  = 3'd4;
  localparam logic [2:0] ST_BADESC  = 3'd5;
  localparam logic [2:0] ST_CTRL    = 3'd6;

  // replacement character
  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;

  // work caused by one input item: up to two code points, then an optional status
  typedef struct packed {
    logic [CP_W-1:0] cp0;
    logic            raw0;
    logic [CP_W-1:0] cp1;
    logic            raw1;
    logic [1:0]      n_cp;
    logic            fin;
    logic [2:0]      st;
  } desc_t;

endpackage

@@ rtl/core/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Classifier: one byte per cycle while the queue has room; advances the string
// parser state and builds a descriptor of the byte's code points and status.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          end_of_input,
  input  logic          q_full,
  output logic          push,
  output jsu_pkg::desc_t push_desc
);

  // parser phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_STR      = 3'd1;
  localparam logic [2:0] PH_ESC      = 3'd2;
  localparam logic [2:0] PH_HEX      = 3'd3;
  localparam logic [2:0] PH_HELD     = 3'd4;
  localparam logic [2:0] PH_HELD_ESC = 3'd5;
  localparam logic [2:0] PH_HEX2     = 3'd6;

  // characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0]     phase;
    logic [15:0]    cu;
    logic [1:0]     dc;
    logic [9:0]     hh;
    jsu_pkg::desc_t d;
  } work_t;

  logic [2:0]  phase;
  logic [15:0] code_unit;
  logic [1:0]  digit_count;
  logic [9:0]  held_high_half;
  work_t       w_in;
  work_t       w_out;

  // append a code point to the descriptor
  function automatic work_t add_cp(work_t w, logic [jsu_pkg::CP_W-1:0] cp, logic raw);
    work_t r;
    r = w;
    if (w.d.n_cp == 2'd0) begin
      r.d.cp0  = cp;
      r.d.raw0 = raw;
    end else begin
      r.d.cp1  = cp;
      r.d.raw1 = raw;
    end
    r.d.n_cp = w.d.n_cp + 2'd1;
    return r;
  endfunction

  function automatic work_t finish(work_t w, logic [2:0] st);
    work_t r;
    r = w;
    r.d.fin = 1'b1;
    r.d.st  = st;
    r.phase = PH_IDLE;
    return r;
  endfunction

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic work_t content(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_QUOTE) r = finish(w, jsu_pkg::ST_OK);
    else if (c == CH_BSL) r.phase = PH_ESC;
    else if (c < CH_SPACE) r = finish(w, jsu_pkg::ST_CTRL);
    else begin
      r = add_cp(w, {13'd0, c}, 1'b1);
      r.phase = PH_STR;
    end
    return r;
  endfunction

  function automatic work_t escape(work_t w, logic [7:0] c);
    work_t      r;
    logic [7:0] v;
    logic       ok;
    r  = w;
    v  = c;
    ok = 1'b1;
    case (c)
      CH_QUOTE, CH_BSL, CH_SLASH: v = c;
      CH_B: v = 8'h08;
      CH_F: v = 8'h0C;
      CH_N: v = 8'h0A;
      CH_R: v = 8'h0D;
      CH_T: v = 8'h09;
      default: ok = 1'b0;
    endcase
    if (c == CH_U) begin
      r.phase = PH_HEX;
      r.cu    = 16'd0;
      r.dc    = 2'd0;
    end else if (!ok) begin
      r = finish(w, jsu_pkg::ST_BADESC);
    end else begin
      r = add_cp(w, {13'd0, v}, 1'b0);
      r.phase = PH_STR;
    end
    return r;
  endfunction

  function automatic work_t unit_alone(work_t w, logic [15:0] cu);
    work_t r;
    r = w;
    if (cu[15:10] == 6'b110110) begin
      r.hh    = cu[9:0];
      r.phase = PH_HELD;
    end else begin
      if (cu[15:10] == 6'b110111) r = add_cp(w, jsu_pkg::CP_REPL, 1'b0);
      else r = add_cp(w, {5'd0, cu}, 1'b0);
      r.phase = PH_STR;
    end
    return r;
  endfunction

  function automatic work_t unit_second(work_t w, logic [15:0] cu);
    work_t r;
    if (cu[15:10] == 6'b110111) begin
      r = add_cp(w, 21'h010000 + {1'b0, w.hh, cu[9:0]}, 1'b0);
      r.phase = PH_STR;
    end else begin
      r = add_cp(w, jsu_pkg::CP_REPL, 1'b0);
      r = unit_alone(r, cu);
    end
    return r;
  endfunction

  function automatic work_t hex(work_t w, logic [7:0] c, logic second);
    work_t      r;
    logic [4:0] hv;
    r  = w;
    hv = hex_value(c);
    if (!hv[4]) begin
      if (second) r = add_cp(r, jsu_pkg::CP_REPL, 1'b0);
      r = finish(r, jsu_pkg::ST_BADHEX);
    end else begin
      r.cu = {w.cu[11:0], hv[3:0]};
      if (w.dc == 2'd3) begin
        r.dc = 2'd0;
        if (second) r = unit_second(r, r.cu);
        else r = unit_alone(r, r.cu);
      end else begin
        r.dc = w.dc + 2'd1;
      end
    end
    return r;
  endfunction

  // current state into the work record
  always_comb begin
    w_in       = '0;
    w_in.phase = phase;
    w_in.cu    = code_unit;
    w_in.dc    = digit_count;
    w_in.hh    = held_high_half;
  end

  // one byte through the parser, then end-of-input handling
  always_comb begin
    work_t w;
    w = w_in;
    case (phase)
      PH_STR: w = content(w, in_byte);
      PH_ESC: w = escape(w, in_byte);
      PH_HEX: w = hex(w, in_byte, 1'b0);
      PH_HELD: begin
        if (in_byte == CH_BSL) w.phase = PH_HELD_ESC;
        else w = content(add_cp(w, jsu_pkg::CP_REPL, 1'b0), in_byte);
      end
      PH_HELD_ESC: begin
        if (in_byte == CH_U) begin
          w.phase = PH_HEX2;
          w.cu    = 16'd0;
          w.dc    = 2'd0;
        end else begin
          w = escape(add_cp(w, jsu_pkg::CP_REPL, 1'b0), in_byte);
        end
      end
      PH_HEX2: w = hex(w, in_byte, 1'b1);
      default: begin
        if (in_byte == CH_QUOTE) w.phase = PH_STR;
        else w = finish(w, jsu_pkg::ST_NOQUOTE);
      end
    endcase
    if (end_of_input) begin
      case (w.phase)
        PH_STR: w = finish(w, jsu_pkg::ST_UNCLOSE);
        PH_ESC: w = finish(w, jsu_pkg::ST_ESCEND);
        PH_HEX: w = finish(w, jsu_pkg::ST_BADHEX);
        PH_HELD: w = finish(add_cp(w, jsu_pkg::CP_REPL, 1'b0), jsu_pkg::ST_UNCLOSE);
        PH_HELD_ESC: w = finish(add_cp(w, jsu_pkg::CP_REPL, 1'b0), jsu_pkg::ST_ESCEND);
        PH_HEX2: w = finish(add_cp(w, jsu_pkg::CP_REPL, 1'b0), jsu_pkg::ST_BADHEX);
        default: w.phase = PH_IDLE;
      endcase
    end
    w_out = w;
  end

  // handshake and queue push
  assign in_ready  = !q_full;
  assign push_desc = w_out.d;
  assign push      = in_valid && in_ready && (w_out.d.fin || (w_out.d.n_cp != 2'd0));

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      code_unit      <= 16'd0;
      digit_count    <= 2'd0;
      held_high_half <= 10'd0;
    end else if (in_valid && in_ready) begin
      phase          <= w_out.phase;
      code_unit      <= w_out.cu;
      digit_count    <= w_out.dc;
      held_high_half <= w_out.hh;
    end
  end

endmodule

@@ rtl/core/jsu_fifo.sv @@
// ----------------------------------------------------------------------------
// jsu_fifo
// Descriptor queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jsu_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output jsu_pkg::desc_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::desc_t   slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_desc;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

@@ rtl/core/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// Byte sequencer: walks a descriptor into an output register, one result per
// cycle when the output is taken: UTF-8 code points, then any status result.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  jsu_pkg::desc_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           kind,
  output logic [2:0]     status,
  output logic           last_of_run
);

  jsu_pkg::desc_t cur;
  logic           cur_valid;
  logic [2:0]     idx;
  logic [2:0]     len0;
  logic [2:0]     len1;
  logic [3:0]     total;
  logic [3:0]     i4;
  logic [3:0]     k1;
  logic           advance;
  logic           is_last;
  logic [7:0]     byte_sel;
  logic           kind_sel;

  // utf-8 length of one entry
  function automatic logic [2:0] utf8_len(logic [jsu_pkg::CP_W-1:0] cp, logic raw);
    logic [2:0] r;
    if (raw || cp < 21'h80) r = 3'd1;
    else if (cp < 21'h800) r = 3'd2;
    else if (cp < 21'h10000) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  // byte k of the utf-8 form of one entry
  function automatic logic [7:0] utf8_byte(logic [jsu_pkg::CP_W-1:0] cp, logic raw,
                                           logic [1:0] k);
    logic [7:0] r;
    logic [2:0] n;
    n = utf8_len(cp, raw);
    r = cp[7:0];
    case (n)
      3'd2: r = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        case (k)
          2'd0: r = {4'b1110, cp[15:12]};
          2'd1: r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (k)
          2'd0: r = {5'b11110, cp[20:18]};
          2'd1: r = {2'b10, cp[17:12]};
          2'd2: r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: r = cp[7:0];
    endcase
    return r;
  endfunction

  // result sequence of the current descriptor
  always_comb begin
    len0  = (cur.n_cp != 2'd0) ? utf8_len(cur.cp0, cur.raw0) : 3'd0;
    len1  = (cur.n_cp == 2'd2) ? utf8_len(cur.cp1, cur.raw1) : 3'd0;
    total = {1'b0, len0} + {1'b0, len1} + {3'd0, cur.fin};
    i4    = {1'b0, idx};
    k1    = i4 - {1'b0, len0};
    is_last = (i4 == total - 4'd1);
    if (i4 < {1'b0, len0}) begin
      byte_sel = utf8_byte(cur.cp0, cur.raw0, idx[1:0]);
      kind_sel = 1'b0;
    end else if (i4 < {1'b0, len0} + {1'b0, len1}) begin
      byte_sel = utf8_byte(cur.cp1, cur.raw1, k1[1:0]);
      kind_sel = 1'b0;
    end else begin
      byte_sel = 8'd0;
      kind_sel = 1'b1;
    end
  end

  assign advance = cur_valid && (!out_valid || out_ready);
  assign pop     = q_not_empty && (!cur_valid || (advance && is_last));

  // descriptor walk
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 3'd0;
    end else if (advance) begin
      if (is_last) cur_valid <= 1'b0;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= byte_sel;
      kind        <= kind_sel;
      status      <= kind_sel ? cur.st : 3'd0;
      last_of_run <= is_last;
    end
  end

  // checks
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("pop from an empty queue");

  a_head_has_work: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_head.fin || q_head.n_cp != 2'd0))
    else $error("descriptor without results");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (i4 < total))
    else $error("sequencer index past end of descriptor");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (advance && kind_sel) |-> is_last)
    else $error("status result not last of its run");

endmodule

@@ rtl/core/json_string_unescape_utf8_core.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string literal unescaper with UTF-8 output and end-of-string status.
// ----------------------------------------------------------------------------
// One input byte is accepted per cycle while the descriptor queue has room;
// the classifier settles each byte, escapes and surrogate pairs included, in
// that cycle. Results leave the byte sequencer one per cycle while the output
// is taken, so an item that causes n results (at most 8) keeps the output busy
// for all n, and the QUEUE_DEPTH-entry queue absorbs those bursts. An item
// with no result costs the output side nothing. The first result of an item
// goes through a queue slot, the descriptor register and the output register.
module json_string_unescape_utf8_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       kind,
  output logic [2:0] status,
  output logic       last_of_run
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  jsu_pkg::desc_t push_desc;
  jsu_pkg::desc_t q_head;

  // classifier
  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .push         (q_push),
    .push_desc    (push_desc)
  );

  // descriptor queue
  jsu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // byte sequencer
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule
